@@ rtl/core/rddq_pkg.sv @@
// rddq_pkg: shared types, constants and helpers of the detent quantizer
// no dependencies
package rddq_pkg;

  localparam int STEP_THRESHOLD = 15;
  localparam int CLAMP_LIMIT    = 30;

  localparam int DELTA_W   = 12;
  localparam int WHEEL_W   = 7;
  localparam int ACC_W     = DELTA_W + 1;
  localparam int SUM_W     = 32;
  localparam int ABS_W     = SUM_W - 1;
  localparam int TARGET_W  = 16;
  localparam int RESIST_W  = 12;
  localparam int PROD_W    = TARGET_W + RESIST_W;
  localparam int DIV_STEPS = PROD_W;
  localparam int CNT_W     = $clog2(DIV_STEPS + 1);

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RESIST = 2'd2;

  localparam logic [1:0] MODE_CAL    = 2'd1;
  localparam logic [1:0] MODE_VERIFY = 2'd2;

  localparam logic [1:0] STEP_NONE = 2'b00;
  localparam logic [1:0] STEP_UP   = 2'b01;
  localparam logic [1:0] STEP_DOWN = 2'b11;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_LOAD,
    ST_DIV,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic capture;
    logic update;
    logic load_div;
    logic div_step;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic div_last;
  } sts_t;

  function automatic logic [SUM_W-1:0] sat_add(logic [SUM_W-1:0] a, logic [DELTA_W-1:0] d);
    logic [SUM_W:0] s;
    s = {a[SUM_W-1], a} + {{(SUM_W + 1 - DELTA_W){d[DELTA_W-1]}}, d};
    if (s[SUM_W] != s[SUM_W-1]) begin
      sat_add = s[SUM_W] ? {1'b1, {(SUM_W - 1){1'b0}}} : {1'b0, {(SUM_W - 1){1'b1}}};
    end else begin
      sat_add = s[SUM_W-1:0];
    end
  endfunction

  function automatic logic [SUM_W-1:0] magnitude(logic [SUM_W-1:0] v);
    magnitude = v[SUM_W-1] ? (~v + SUM_W'(1)) : v;
  endfunction

endpackage

@@ rtl/core/rotary_delta_detent_quantizer.sv @@
// rotary_delta_detent_quantizer: top level, controller plus datapath
// per sample: capture, update, divider load, bit-serial 28-step divide, finish
// no new sample is taken until its predecessor reaches the output register
// a finished result waits in the output register while the next sample runs
// reset: asynchronous active low, clears FSM, config, wheel accumulator, both sums
// depends on rddq_pkg, rddq_ctrl, rddq_dpath
module rotary_delta_detent_quantizer (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [rddq_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [rddq_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                burst_start_i,
  input  logic [7:0]                          delta_x_low_i,
  input  logic [7:0]                          delta_xy_high_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [1:0]                   wheel_step_o,
  output logic signed [rddq_pkg::DELTA_W-1:0] motion_delta_o,
  output logic [rddq_pkg::ABS_W-1:0]          calibration_sum_abs_o,
  output logic [rddq_pkg::ABS_W-1:0]          verify_sum_abs_o,
  output logic [rddq_pkg::PROD_W-1:0]         rescaled_resistance_o,
  output logic                                divide_by_zero_o
);
  import rddq_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready_o = 1'b1;

  rddq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  rddq_dpath u_dpath (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .cfg_we_i              (cfg_valid_i && cfg_ready_o),
    .cfg_index_i           (cfg_index_i),
    .cfg_data_i            (cfg_data_i),
    .burst_start_i         (burst_start_i),
    .delta_x_low_i         (delta_x_low_i),
    .delta_xy_high_i       (delta_xy_high_i),
    .cmd_i                 (cmd),
    .sts_o                 (sts),
    .wheel_step_o          (wheel_step_o),
    .motion_delta_o        (motion_delta_o),
    .calibration_sum_abs_o (calibration_sum_abs_o),
    .verify_sum_abs_o      (verify_sum_abs_o),
    .rescaled_resistance_o (rescaled_resistance_o),
    .divide_by_zero_o      (divide_by_zero_o)
  );

endmodule

@@ rtl/core/rddq_ctrl.sv @@
// rddq_ctrl: sequencing state machine and output valid of the detent quantizer
// depends on rddq_pkg
module rddq_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  input  rddq_pkg::sts_t sts_i,
  output rddq_pkg::cmd_t cmd_o
);
  import rddq_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        cmd_o.update = 1'b1;
        state_d      = ST_LOAD;
      end
      ST_LOAD: begin
        cmd_o.load_div = 1'b1;
        state_d        = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE && in_valid_i) |=> (state_q == ST_UPDATE))
    else $error("accepted sample did not start processing");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |=> out_valid_q)
    else $error("stalled result lost");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FINISH && out_valid_q && out_stall_i) |=> (state_q == ST_FINISH))
    else $error("result overwritten while output held");

endmodule

@@ rtl/core/rddq_dpath.sv @@
// rddq_dpath: registers, wheel and sum update, multiplier and serial divider
// depends on rddq_pkg
module rddq_dpath (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [rddq_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [rddq_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  logic                               burst_start_i,
  input  logic [7:0]                         delta_x_low_i,
  input  logic [7:0]                         delta_xy_high_i,
  input  rddq_pkg::cmd_t                     cmd_i,
  output rddq_pkg::sts_t                     sts_o,
  output logic signed [1:0]                  wheel_step_o,
  output logic signed [rddq_pkg::DELTA_W-1:0] motion_delta_o,
  output logic [rddq_pkg::ABS_W-1:0]         calibration_sum_abs_o,
  output logic [rddq_pkg::ABS_W-1:0]         verify_sum_abs_o,
  output logic [rddq_pkg::PROD_W-1:0]        rescaled_resistance_o,
  output logic                               divide_by_zero_o
);
  import rddq_pkg::*;

  localparam logic signed [ACC_W-1:0] THR_P = ACC_W'(STEP_THRESHOLD);
  localparam logic signed [ACC_W-1:0] THR_N = ACC_W'(-STEP_THRESHOLD);
  localparam logic signed [ACC_W-1:0] CLP_P = ACC_W'(CLAMP_LIMIT);
  localparam logic signed [ACC_W-1:0] CLP_N = ACC_W'(-CLAMP_LIMIT);
  localparam logic [ABS_W-1:0]        ABS_MAX = '1;

  logic [1:0]            mode_q;
  logic [TARGET_W-1:0]   target_q;
  logic [RESIST_W-1:0]   resist_q;
  logic [WHEEL_W-1:0]    wheel_q;
  logic [SUM_W-1:0]      cal_q;
  logic [SUM_W-1:0]      ver_q;

  logic                  burst_q;
  logic [DELTA_W-1:0]    delta_q;
  logic [1:0]            step_q, step_d;
  logic [PROD_W-1:0]     prod_q;
  logic [SUM_W-1:0]      divisor_q;
  logic [SUM_W-1:0]      rem_q;
  logic [PROD_W-1:0]     quo_q;
  logic [CNT_W-1:0]      cnt_q;

  logic [WHEEL_W-1:0]    wheel_base;
  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-1:0] acc_new;
  logic                  mode_wheel;
  logic [SUM_W-1:0]      rem_sh;
  logic                  rem_ge;
  logic [SUM_W-1:0]      ver_mag;
  logic                  div_zero;

  assign mode_wheel = (mode_q != MODE_CAL) && (mode_q != MODE_VERIFY);
  assign wheel_base = burst_q ? '0 : wheel_q;
  assign acc = $signed({{(ACC_W - WHEEL_W){wheel_base[WHEEL_W-1]}}, wheel_base})
             + $signed({delta_q[DELTA_W-1], delta_q});

  always_comb begin
    acc_new = acc;
    step_d  = STEP_NONE;
    if (acc > THR_P) begin
      acc_new = (acc > CLP_P) ? CLP_P : (acc - THR_P);
      step_d  = STEP_DOWN;
    end else if (acc < THR_N) begin
      acc_new = (acc < CLP_N) ? CLP_N : (acc + THR_P);
      step_d  = STEP_UP;
    end
  end

  assign rem_sh   = {rem_q[SUM_W-2:0], quo_q[PROD_W-1]};
  assign rem_ge   = (rem_sh >= divisor_q);
  assign ver_mag  = magnitude(ver_q);
  assign div_zero = (divisor_q == '0);
  assign sts_o.div_last = (cnt_q == CNT_W'(1));

  // configuration registers and running state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= '0;
      target_q <= '0;
      resist_q <= '0;
      wheel_q  <= '0;
      cal_q    <= '0;
      ver_q    <= '0;
      cnt_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_MODE: begin
            mode_q <= cfg_data_i[1:0];
            if (cfg_data_i[1:0] == MODE_CAL) begin
              cal_q <= '0;
            end else if (cfg_data_i[1:0] == MODE_VERIFY) begin
              ver_q <= '0;
            end
          end
          CFG_TARGET: target_q <= cfg_data_i[TARGET_W-1:0];
          CFG_RESIST: resist_q <= cfg_data_i[RESIST_W-1:0];
          default: ;
        endcase
      end
      if (cmd_i.update) begin
        if (mode_q == MODE_CAL) begin
          cal_q   <= sat_add(cal_q, delta_q);
          wheel_q <= wheel_base;
        end else if (mode_q == MODE_VERIFY) begin
          ver_q   <= sat_add(ver_q, delta_q);
          wheel_q <= wheel_base;
        end else begin
          wheel_q <= acc_new[WHEEL_W-1:0];
        end
      end
      if (cmd_i.load_div) begin
        cnt_q <= CNT_W'(DIV_STEPS);
      end else if (cmd_i.div_step) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

  // sample capture, product and restoring divider
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      burst_q <= burst_start_i;
      delta_q <= {delta_xy_high_i[7:4], delta_x_low_i};
    end
    if (cmd_i.update) begin
      step_q <= mode_wheel ? step_d : STEP_NONE;
      prod_q <= {{TARGET_W{1'b0}}, resist_q} * {{RESIST_W{1'b0}}, target_q};
    end
    if (cmd_i.load_div) begin
      divisor_q <= magnitude(cal_q);
      rem_q     <= '0;
      quo_q     <= prod_q;
    end else if (cmd_i.div_step) begin
      rem_q <= rem_ge ? (rem_sh - divisor_q) : rem_sh;
      quo_q <= {quo_q[PROD_W-2:0], rem_ge};
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      wheel_step_o          <= $signed(step_q);
      motion_delta_o        <= $signed(delta_q);
      calibration_sum_abs_o <= divisor_q[SUM_W-1] ? ABS_MAX : divisor_q[ABS_W-1:0];
      verify_sum_abs_o      <= ver_mag[SUM_W-1] ? ABS_MAX : ver_mag[ABS_W-1:0];
      rescaled_resistance_o <= div_zero ? '0 : quo_q;
      divide_by_zero_o      <= div_zero;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_out |=> (!divide_by_zero_o || (rescaled_resistance_o == '0)))
    else $error("quotient reported on zero divisor");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_step |-> (cnt_q != '0))
    else $error("divider stepped past its last bit");

endmodule

@@ sim/tb_rotary_delta_detent_quantizer.sv @@
// tb_rotary_delta_detent_quantizer: self-checking bench for the detent quantizer, directed
// table then randomised phases, results checked against the table or an in-bench predictor
// depends on rddq_pkg and rotary_delta_detent_quantizer
module tb_rotary_delta_detent_quantizer;
  import rddq_pkg::*;

  localparam logic [1:0] MODE_WHEEL = 2'd0;
  localparam logic [1:0] MODE_SPARE = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam int DETENT_THRESH = 15;
  localparam int DETENT_CLAMP = 30;
  localparam longint MAX_ABS = 64'sd2147483647;
  localparam int LONG_HOLD = 400;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int RANDOM_ITEMS = 1850;
  localparam int END_WAIT = 40;

  typedef struct packed {
    logic signed [1:0]         step;
    logic signed [DELTA_W-1:0] delta;
    logic [ABS_W-1:0]          cal_abs;
    logic [ABS_W-1:0]          ver_abs;
    logic [PROD_W-1:0]         rescaled;
    logic                      dz;
  } detent_res_t;

  typedef enum logic [1:0] {ROW_SAMPLE, ROW_CHECKED, ROW_REG} row_kind_e;

  typedef struct packed {
    row_kind_e             kind;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_DATA_W-1:0] reg_data;
    logic                  burst;
    logic [7:0]            lo;
    logic [7:0]            hi;
    detent_res_t           res;
  } stim_row_t;

  localparam detent_res_t NO_RES = '0;

  localparam stim_row_t DIRECTED [31] = '{
    '{ROW_CHECKED, CFG_MODE, 16'h0000, 1'b1, 8'h00, 8'h00,
      '{STEP_NONE, 12'sd0, 31'd0, 31'd0, 28'd0, 1'b1}},
    '{ROW_CHECKED, CFG_MODE, 16'h0000, 1'b1, 8'hFF, 8'h7F,
      '{STEP_DOWN, 12'sd2047, 31'd0, 31'd0, 28'd0, 1'b1}},
    '{ROW_CHECKED, CFG_MODE, 16'h0000, 1'b0, 8'h00, 8'h80,
      '{STEP_UP, -12'sd2048, 31'd0, 31'd0, 28'd0, 1'b1}},
    '{ROW_SAMPLE, CFG_MODE, 16'h0000, 1'b1, 8'h0F, 8'h0F, NO_RES},
    '{ROW_SAMPLE, CFG_MODE, 16'h0000, 1'b0, 8'h01, 8'h00, NO_RES},
    '{ROW_SAMPLE, CFG_MODE, 16'h0000, 1'b1, 8'hF0, 8'hF0, NO_RES},
    '{ROW_SAMPLE, CFG_MODE, 16'h0000, 1'b1, 8'hF1, 8'hFF, NO_RES},
    '{ROW_SAMPLE, CFG_MODE, 16'h0000, 1'b0, 8'h0F, 8'h00, NO_RES},
    '{ROW_SAMPLE, CFG_MODE, 16'h0000, 1'b0, 8'h1F, 8'h00, NO_RES},
    '{ROW_SAMPLE, CFG_MODE, 16'h0000, 1'b0, 8'h01, 8'h00, NO_RES},
    '{ROW_REG, CFG_TARGET, 16'hFFFF, 1'b0, 8'h00, 8'h00, NO_RES},
    '{ROW_REG, CFG_RESIST, 16'hFFFF, 1'b0, 8'h00, 8'h00, NO_RES},
    '{ROW_REG, CFG_MODE, {14'd0, MODE_CAL}, 1'b0, 8'h00, 8'h00, NO_RES},
    '{ROW_CHECKED, CFG_MODE, 16'h0000, 1'b0, 8'h01, 8'h00,
      '{STEP_NONE, 12'sd1, 31'd1, 31'd0, 28'd268365825, 1'b0}},
    '{ROW_SAMPLE, CFG_MODE, 16'h0000, 1'b1, 8'h00, 8'h80, NO_RES},
    '{ROW_SAMPLE, CFG_MODE, 16'h0000, 1'b0, 8'h00, 8'h80, NO_RES},
    '{ROW_SAMPLE, CFG_MODE, 16'h0000, 1'b0, 8'hFF, 8'h7F, NO_RES},
    '{ROW_REG, CFG_MODE, {14'd0, MODE_VERIFY}, 1'b0, 8'h00, 8'h00, NO_RES},
    '{ROW_SAMPLE, CFG_MODE, 16'h0000, 1'b0, 8'h00, 8'h80, NO_RES},
    '{ROW_SAMPLE, CFG_MODE, 16'h0000, 1'b0, 8'hFF, 8'hFF, NO_RES},
    '{ROW_REG, CFG_MODE, {14'd0, MODE_SPARE}, 1'b0, 8'h00, 8'h00, NO_RES},
    '{ROW_SAMPLE, CFG_MODE, 16'h0000, 1'b0, 8'h10, 8'h00, NO_RES},
    '{ROW_SAMPLE, CFG_MODE, 16'h0000, 1'b0, 8'hE0, 8'hFF, NO_RES},
    '{ROW_REG, CFG_UNUSED, 16'hFFFF, 1'b0, 8'h00, 8'h00, NO_RES},
    '{ROW_REG, CFG_MODE, {14'd0, MODE_CAL}, 1'b0, 8'h00, 8'h00, NO_RES},
    '{ROW_CHECKED, CFG_MODE, 16'h0000, 1'b0, 8'h00, 8'h00,
      '{STEP_NONE, 12'sd0, 31'd0, 31'd2049, 28'd0, 1'b1}},
    '{ROW_REG, CFG_TARGET, 16'h0000, 1'b0, 8'h00, 8'h00, NO_RES},
    '{ROW_REG, CFG_RESIST, 16'h0000, 1'b0, 8'h00, 8'h00, NO_RES},
    '{ROW_SAMPLE, CFG_MODE, 16'h0000, 1'b0, 8'h05, 8'h00, NO_RES},
    '{ROW_REG, CFG_MODE, {14'd1, MODE_WHEEL}, 1'b0, 8'h00, 8'h00, NO_RES},
    '{ROW_SAMPLE, CFG_MODE, 16'h0000, 1'b1, 8'h00, 8'h00, NO_RES}
  };

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  in_valid_i;
  logic                  in_stall_o;
  logic                  burst_start_i;
  logic [7:0]            delta_x_low_i;
  logic [7:0]            delta_xy_high_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  logic signed [1:0]     wheel_step_o;
  logic signed [DELTA_W-1:0] motion_delta_o;
  logic [ABS_W-1:0]      calibration_sum_abs_o;
  logic [ABS_W-1:0]      verify_sum_abs_o;
  logic [PROD_W-1:0]     rescaled_resistance_o;
  logic                  divide_by_zero_o;

  detent_res_t pending_detent_q[$];
  int          err_cnt;
  int          results_seen;
  int          stuck_cycles;
  logic        quiet;

  logic [1:0]      cur_mode;
  logic [15:0]     cur_target;
  logic [11:0]     cur_resist;
  int              wheel_acc;
  longint          cal_sum;
  longint          ver_sum;

  rotary_delta_detent_quantizer u_top (.*);

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic longint clip32(longint v);
    if (v > MAX_ABS) return MAX_ABS;
    if (v < -MAX_ABS - 1) return -MAX_ABS - 1;
    return v;
  endfunction

  function automatic void apply_reg_write(logic [CFG_IDX_W-1:0] idx, logic [15:0] data);
    case (idx)
      CFG_MODE: begin
        cur_mode = data[1:0];
        if (cur_mode == MODE_CAL) cal_sum = 0;
        else if (cur_mode == MODE_VERIFY) ver_sum = 0;
      end
      CFG_TARGET: cur_target = data;
      CFG_RESIST: cur_resist = data[11:0];
      default: ;
    endcase
  endfunction

  function automatic detent_res_t predict_detent(logic burst, logic [7:0] lo, logic [7:0] hi);
    detent_res_t r;
    logic [DELTA_W-1:0] raw;
    int d;
    int acc;
    longint cmag;
    longint vmag;
    raw = {hi[7:4], lo};
    d = raw[DELTA_W-1] ? int'(raw) - 4096 : int'(raw);
    r = '0;
    r.delta = raw;
    if (burst) wheel_acc = 0;
    case (cur_mode)
      MODE_CAL: cal_sum = clip32(cal_sum + d);
      MODE_VERIFY: ver_sum = clip32(ver_sum + d);
      default: begin
        acc = wheel_acc + d;
        if (acc > DETENT_THRESH) begin
          r.step = STEP_DOWN;
          acc = (acc > DETENT_CLAMP) ? DETENT_CLAMP : acc - DETENT_THRESH;
        end else if (acc < -DETENT_THRESH) begin
          r.step = STEP_UP;
          acc = (acc < -DETENT_CLAMP) ? -DETENT_CLAMP : acc + DETENT_THRESH;
        end
        wheel_acc = acc;
      end
    endcase
    cmag = (cal_sum < 0) ? -cal_sum : cal_sum;
    vmag = (ver_sum < 0) ? -ver_sum : ver_sum;
    r.cal_abs = (cmag > MAX_ABS) ? ABS_W'(MAX_ABS) : ABS_W'(cmag);
    r.ver_abs = (vmag > MAX_ABS) ? ABS_W'(MAX_ABS) : ABS_W'(vmag);
    if (cmag == 0) begin
      r.dz = 1'b1;
    end else begin
      r.rescaled = PROD_W'((longint'(cur_resist) * longint'(cur_target)) / cmag);
    end
    return r;
  endfunction

  function automatic int idle_len();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 5) return 0;
    if (sel < 9) return $urandom_range(1, 4);
    return $urandom_range(20, 60);
  endfunction

  function automatic void check_field(string name, longint want, longint got);
    if (want != got) begin
      err_cnt++;
      $display("%0t: %s expected %0d got %0d", $time, name, want, got);
    end
  endfunction

  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_detent_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    apply_reg_write(idx, data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic send_sample(input logic burst, input logic [7:0] lo, input logic [7:0] hi,
                             input logic typed, input detent_res_t typed_res);
    detent_res_t r;
    int gap;
    gap = quiet ? 0 : idle_len();
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i      <= 1'b1;
    burst_start_i   <= burst;
    delta_x_low_i   <= lo;
    delta_xy_high_i <= hi;
    do @(posedge clk_i); while (in_stall_o);
    r = predict_detent(burst, lo, hi);
    pending_detent_q.push_back(typed ? typed_res : r);
  endtask

  // receiver: random stalls plus two long hold-offs to back the block up
  initial begin : rx_p
    int holds_done;
    int stall_len;
    holds_done = 0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (holds_done < 2 && results_seen >= (holds_done + 1) * 600) begin
        holds_done++;
        out_stall_i <= 1'b1;
        repeat (LONG_HOLD) @(negedge clk_i);
      end
      stall_len = quiet ? 0 : idle_len();
      if (stall_len == 0) begin
        out_stall_i <= 1'b0;
      end else begin
        out_stall_i <= 1'b1;
        repeat (stall_len - 1) @(negedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin : check_p
    detent_res_t want;
    if (out_valid_o && !out_stall_i) begin
      results_seen++;
      if (pending_detent_q.size() == 0) begin
        err_cnt++;
        $display("%0t: result transfer with nothing expected", $time);
      end else begin
        want = pending_detent_q.pop_front();
        check_field("wheel_step", want.step, wheel_step_o);
        check_field("motion_delta", want.delta, motion_delta_o);
        check_field("calibration_sum_abs", want.cal_abs, calibration_sum_abs_o);
        check_field("verify_sum_abs", want.ver_abs, verify_sum_abs_o);
        check_field("rescaled_resistance", want.rescaled, rescaled_resistance_o);
        check_field("divide_by_zero", want.dz, divide_by_zero_o);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      stuck_cycles = 0;
    end else begin
      stuck_cycles++;
    end
    if (stuck_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, stuck_cycles);
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin : main_p
    int rand_sent;
    int n;
    int sel;
    int t;
    logic [1:0] mode_code;
    logic [CFG_IDX_W-1:0] idx;
    logic [15:0] data;
    logic [11:0] raw;
    err_cnt = 0;
    results_seen = 0;
    stuck_cycles = 0;
    quiet = 1'b0;
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    burst_start_i = 1'b0;
    delta_x_low_i = '0;
    delta_xy_high_i = '0;
    cur_mode = MODE_WHEEL;
    cur_target = '0;
    cur_resist = '0;
    wheel_acc = 0;
    cal_sum = 0;
    ver_sum = 0;
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (DIRECTED[i]) begin
      if (DIRECTED[i].kind == ROW_REG) begin
        drain();
        write_reg(DIRECTED[i].reg_idx, DIRECTED[i].reg_data);
      end else begin
        send_sample(DIRECTED[i].burst, DIRECTED[i].lo, DIRECTED[i].hi,
                    DIRECTED[i].kind == ROW_CHECKED, DIRECTED[i].res);
      end
    end

    rand_sent = 0;
    while (rand_sent < RANDOM_ITEMS) begin
      drain();
      quiet = ($urandom_range(0, 4) == 0);
      sel = $urandom_range(0, 9);
      if (sel < 4) mode_code = MODE_WHEEL;
      else if (sel < 7) mode_code = MODE_CAL;
      else if (sel < 9) mode_code = MODE_VERIFY;
      else mode_code = MODE_SPARE;
      write_reg(CFG_MODE, {(($urandom_range(0, 3) == 0) ? 14'($urandom) : 14'd0), mode_code});
      repeat ($urandom_range(0, 2)) begin
        idx = CFG_IDX_W'($urandom_range(0, 3));
        case ($urandom_range(0, 3))
          0: data = 16'h0000;
          1: data = 16'hFFFF;
          2: data = 16'h0FFF;
          default: data = 16'($urandom);
        endcase
        write_reg(idx, data);
      end
      n = $urandom_range(10, 60);
      for (int k = 0; k < n; k++) begin
        sel = $urandom_range(0, 19);
        if (sel < 13) begin
          raw = 12'(int'($urandom_range(0, 80)) - 40);
        end else if (sel < 16) begin
          raw = 12'($urandom);
        end else if (sel < 18) begin
          case ($urandom_range(0, 3))
            0: raw = 12'h7FF;
            1: raw = 12'h800;
            2: raw = 12'h000;
            default: raw = 12'hFFF;
          endcase
        end else begin
          t = ($urandom_range(0, 1) == 0) ? DETENT_THRESH : DETENT_THRESH + 1;
          raw = ($urandom_range(0, 1) == 0) ? 12'(t) : 12'(-t);
        end
        send_sample(($urandom_range(0, 7) == 0), raw[7:0], {raw[11:8], 4'($urandom)},
                    1'b0, NO_RES);
        rand_sent++;
      end
    end

    drain();
    repeat (END_WAIT) @(posedge clk_i);
    if (pending_detent_q.size() != 0) begin
      err_cnt++;
      $display("%0t: %0d results never arrived", $time, pending_detent_q.size());
    end
    if (err_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/rddq_pkg.sv
rtl/core/rddq_ctrl.sv
rtl/core/rddq_dpath.sv
rtl/core/rotary_delta_detent_quantizer.sv
sim/tb_rotary_delta_detent_quantizer.sv
